// ----- rtl/timeout_text_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// timeout_text_decoder_macros
// Assertion helpers for the duration text decoder.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst to be in scope.
`ifndef TIMEOUT_TEXT_DECODER_MACROS_SVH
`define TIMEOUT_TEXT_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TTD_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ttd_pkg.sv -----
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared types, codes and constants of the duration text decoder.
// ----------------------------------------------------------------------------
package ttd_pkg;

  localparam int CountW = 30;
  localparam int SecW   = 42;
  localparam int NsW    = 30;
  localparam int QuotW  = 21;   // largest quotient: 2^30 / 1000
  localparam int MulW   = 31;   // width of the stage-one multiplier constant
  localparam int ProdW  = CountW + MulW;
  localparam int RecipShift = 40;

  localparam int JobDepth = 4;
  localparam int JobPtrW  = $clog2(JobDepth);
  localparam int OutDepth = 8;
  localparam int OutPtrW  = $clog2(OutDepth);

  // unit codes
  localparam logic [2:0] UNIT_NS = 3'd0;
  localparam logic [2:0] UNIT_US = 3'd1;
  localparam logic [2:0] UNIT_MS = 3'd2;
  localparam logic [2:0] UNIT_S  = 3'd3;
  localparam logic [2:0] UNIT_M  = 3'd4;
  localparam logic [2:0] UNIT_H  = 3'd5;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_LM    = 8'h6D;
  localparam logic [7:0] CH_US    = 8'h53;
  localparam logic [7:0] CH_UM    = 8'h4D;
  localparam logic [7:0] CH_UH    = 8'h48;

  localparam logic [CountW-1:0] COUNT_LIMIT = 30'd100_000_000;
  localparam logic [CountW-1:0] NS_PER_S    = 30'd1_000_000_000;
  localparam logic [CountW-1:0] NS_PER_MS   = 30'd1_000_000;
  localparam logic [CountW-1:0] NS_PER_US   = 30'd1_000;

  // floor(2^40 / d), quotient estimate is low by at most one
  localparam logic [MulW-1:0] RECIP_US = 31'd1_099_511;
  localparam logic [MulW-1:0] RECIP_MS = 31'd1_099_511_627;

  typedef struct packed {
    logic              valid_res;
    logic              infinite;
    logic [CountW-1:0] count;
    logic [2:0]        unit;
  } job_t;

  typedef struct packed {
    logic            valid_res;
    logic            infinite;
    logic [SecW-1:0] seconds;
    logic [NsW-1:0]  nanoseconds;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] code;
  } unit_hit_t;

  function automatic unit_hit_t unit_of(input logic [7:0] c);
    unit_hit_t h;
    h.ok = 1'b1;
    unique case (c)
      CH_N:    h.code = UNIT_NS;
      CH_U:    h.code = UNIT_US;
      CH_LM:   h.code = UNIT_MS;
      CH_US:   h.code = UNIT_S;
      CH_UM:   h.code = UNIT_M;
      CH_UH:   h.code = UNIT_H;
      default: begin
        h.ok   = 1'b0;
        h.code = UNIT_S;
      end
    endcase
    return h;
  endfunction

endpackage

// ----- rtl/ttd_front.sv -----
// ----------------------------------------------------------------------------
// ttd_front
// Character parser: tracks the text phase and emits one job per text.
// ----------------------------------------------------------------------------
module ttd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    char_code,
  input  logic          has_char,
  input  logic          last,
  output logic          job_wr,
  output ttd_pkg::job_t job
);
  import ttd_pkg::*;

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_DIGITS = 3'd1;
  localparam logic [2:0] PH_GAP    = 3'd2;
  localparam logic [2:0] PH_TRAIL  = 3'd3;
  localparam logic [2:0] PH_ENDED  = 3'd4;
  localparam logic [2:0] PH_INF    = 3'd5;
  localparam logic [2:0] PH_BAD    = 3'd6;

  logic [2:0]        phase, phase_next;
  logic [CountW-1:0] count_value, count_next;
  logic [2:0]        unit_code, unit_next;
  logic              digit, is_space, good;
  logic [3:0]        dval;
  logic [CountW-1:0] times_ten;
  unit_hit_t         uh;

  assign digit     = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_space  = (char_code == CH_SPACE);
  assign dval      = 4'(char_code - CH_ZERO);
  assign times_ten = {count_value[CountW-4:0], 3'b000} + {count_value[CountW-2:0], 1'b0};
  assign uh        = unit_of(char_code);

  always_comb begin
    phase_next = phase;
    count_next = count_value;
    unit_next  = unit_code;
    if (has_char) begin
      unique case (phase)
        PH_LEAD: begin
          if (is_space) begin
          end else if (digit) begin
            count_next = CountW'(dval);
            phase_next = PH_DIGITS;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_DIGITS: begin
          if (digit) begin
            if (count_value >= COUNT_LIMIT && (count_value != COUNT_LIMIT || dval != 4'd0)) begin
              phase_next = PH_INF;
            end else begin
              count_next = times_ten + CountW'(dval);
            end
          end else if (is_space) begin
            phase_next = PH_GAP;
          end else if (uh.ok) begin
            unit_next  = uh.code;
            phase_next = PH_TRAIL;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_GAP: begin
          if (is_space) begin
          end else if (uh.ok) begin
            unit_next  = uh.code;
            phase_next = PH_TRAIL;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_TRAIL: begin
          if (char_code == CH_NUL) begin
            phase_next = PH_ENDED;
          end else if (!is_space) begin
            phase_next = PH_BAD;
          end
        end
        PH_ENDED, PH_INF, PH_BAD: begin
        end
        default: phase_next = PH_BAD;
      endcase
    end
  end

  // Normalize the job: bad and infinite texts carry a zero count in seconds.
  assign good          = (phase_next == PH_TRAIL) || (phase_next == PH_ENDED);
  assign job_wr        = accept && last;
  assign job.infinite  = (phase_next == PH_INF);
  assign job.valid_res = good || job.infinite;
  assign job.count     = good ? count_next : '0;
  assign job.unit      = good ? unit_next : UNIT_S;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      count_value <= '0;
      unit_code   <= UNIT_NS;
    end else if (accept) begin
      if (last) begin
        phase       <= PH_LEAD;
        count_value <= '0;
        unit_code   <= UNIT_NS;
      end else begin
        phase       <= phase_next;
        count_value <= count_next;
        unit_code   <= unit_next;
      end
    end
  end

endmodule

// ----- rtl/ttd_job_queue.sv -----
// ----------------------------------------------------------------------------
// ttd_job_queue
// Short queue of parsed jobs between the parser and the arithmetic pipe.
// ----------------------------------------------------------------------------
module ttd_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  ttd_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output ttd_pkg::job_t rd_job,
  output logic          empty
);
  import ttd_pkg::*;

  job_t               mem [JobDepth];
  logic [JobPtrW-1:0] wptr, rptr;
  logic [JobPtrW:0]   fill;

  assign full   = (fill == (JobPtrW+1)'(JobDepth));
  assign empty  = (fill == '0);
  assign rd_job = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr_en) wptr <= wptr + 1'b1;
      if (rd_en) rptr <= rptr + 1'b1;
      fill <= fill + (JobPtrW+1)'(wr_en) - (JobPtrW+1)'(rd_en);
    end
  end

endmodule

// ----- rtl/ttd_back.sv -----
// ----------------------------------------------------------------------------
// ttd_back
// Unit conversion pipe (reciprocal divide, remainder fix, scale) and
// result queue.
// ----------------------------------------------------------------------------
module ttd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_avail,
  input  ttd_pkg::job_t    job,
  output logic             job_take,
  input  logic             pop,
  output logic             empty,
  output ttd_pkg::result_t res
);
  import ttd_pkg::*;

  // stage 1: reciprocal or scale multiply
  logic              v1, v2, v3;
  job_t              j1, j2;
  logic [ProdW-1:0]  prod1;
  logic [MulW-1:0]   mconst;
  // stage 2: quotient estimate times divisor
  logic [QuotW-1:0]  q2;
  logic [CountW-1:0] qd2;
  logic [SecW-1:0]   secmul2;
  logic [QuotW-1:0]  q_est;
  logic [CountW-1:0] dsel1, dsel2;
  // stage 3: corrected quotient and remainder
  logic [CountW-1:0] r0, r3;
  logic [QuotW-1:0]  qfix;
  logic [CountW-1:0] rfix;
  logic [SecW-1:0]   sec3;
  logic [CountW-1:0] scale3;
  logic              valid3, inf3;
  logic [CountW-1:0] scale_sel;
  logic [NsW-1:0]    ns_w;
  // result queue
  result_t            oq [OutDepth];
  logic [OutPtrW-1:0] owp, orp;
  logic [OutPtrW:0]   ofill;
  logic [OutPtrW:0]   pending;
  logic               opop;

  // Credit check: queue fill plus items in the pipe must leave a free slot.
  assign pending  = ofill + (OutPtrW+1)'(v1) + (OutPtrW+1)'(v2) + (OutPtrW+1)'(v3);
  assign job_take = job_avail && (pending < (OutPtrW+1)'(OutDepth));

  always_comb begin
    unique case (job.unit)
      UNIT_US: mconst = RECIP_US;
      UNIT_MS: mconst = RECIP_MS;
      UNIT_S:  mconst = MulW'(1);
      UNIT_M:  mconst = MulW'(60);
      UNIT_H:  mconst = MulW'(3600);
      default: mconst = '0;
    endcase
  end

  always_comb begin
    unique case (j1.unit)
      UNIT_NS: dsel1 = NS_PER_S;
      UNIT_US: dsel1 = NS_PER_MS;
      UNIT_MS: dsel1 = NS_PER_US;
      default: dsel1 = '0;
    endcase
  end

  assign q_est = (j1.unit == UNIT_US || j1.unit == UNIT_MS) ?
                 prod1[RecipShift +: QuotW] : '0;

  always_comb begin
    unique case (j2.unit)
      UNIT_NS: dsel2 = NS_PER_S;
      UNIT_US: dsel2 = NS_PER_MS;
      UNIT_MS: dsel2 = NS_PER_US;
      default: dsel2 = '0;
    endcase
    unique case (j2.unit)
      UNIT_NS: scale_sel = CountW'(1);
      UNIT_US: scale_sel = NS_PER_US;
      UNIT_MS: scale_sel = NS_PER_MS;
      default: scale_sel = '0;
    endcase
  end

  assign r0 = j2.count - qd2;
  always_comb begin
    qfix = q2;
    rfix = r0;
    if (r0 >= dsel2) begin
      qfix = q2 + 1'b1;
      rfix = r0 - dsel2;
    end
  end

  assign ns_w = NsW'(r3 * scale3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= job_take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    j1      <= job;
    prod1   <= job.count * mconst;
    j2      <= j1;
    q2      <= q_est;
    qd2     <= CountW'(q_est * dsel1);
    secmul2 <= prod1[SecW-1:0];
    valid3  <= j2.valid_res;
    inf3    <= j2.infinite;
    scale3  <= scale_sel;
    if (j2.unit == UNIT_NS || j2.unit == UNIT_US || j2.unit == UNIT_MS) begin
      r3   <= rfix;
      sec3 <= SecW'(qfix);
    end else begin
      r3   <= '0;
      sec3 <= secmul2;
    end
  end

  // result queue
  assign opop  = pop && !empty;
  assign empty = (ofill == '0);
  assign res   = oq[orp];

  always_ff @(posedge clk) begin
    if (v3) begin
      oq[owp] <= '{valid_res: valid3, infinite: inf3, seconds: sec3, nanoseconds: ns_w};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp   <= '0;
      orp   <= '0;
      ofill <= '0;
    end else begin
      if (v3)   owp <= owp + 1'b1;
      if (opop) orp <= orp + 1'b1;
      ofill <= ofill + (OutPtrW+1)'(v3) - (OutPtrW+1)'(opop);
    end
  end

endmodule

// ----- rtl/timeout_text_decoder.sv -----
// ----------------------------------------------------------------------------
// timeout_text_decoder
// Parses duration text (count plus unit letter) into seconds and nanoseconds.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Payload
// input     in         push / full         char_code, has_char, last
// result    out        empty / pop         valid_res, infinite, seconds,
//                                          nanoseconds
//
// One character transfer per cycle, sustained; full rises only when the
// four-entry job queue holds four finished texts awaiting conversion.
// After the transfer marked last, a result passes through the job queue,
// multiply, quotient times divisor and remainder fix, then the nanosecond
// scale multiply written into the eight-entry result queue.
// Issue into the multiply pipe is credit based, so a stalled result side
// backs up into the job queue and then into full, never dropping a result.
// rst is synchronous and clears the parse state and all queue pointers.
//
`include "timeout_text_decoder_macros.svh"

module timeout_text_decoder (
  input  logic        clk,
  input  logic        rst,
  // character side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code,
  input  logic        has_char,
  input  logic        last,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic        valid_res,
  output logic        infinite,
  output logic [41:0] seconds,
  output logic [29:0] nanoseconds
);
  import ttd_pkg::*;

  logic    accept;
  logic    q_wr, q_full, q_empty, q_rd;
  job_t    q_in, q_out;
  result_t res;
  logic    dur_zero;

  // a character transfer
  assign accept = push && !full;
  assign full   = q_full;

  // front: per-character parse; a job per finished text
  ttd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .has_char  (has_char),
    .last      (last),
    .job_wr    (q_wr),
    .job       (q_in)
  );

  // decoupling queue between parse and conversion
  ttd_job_queue u_jobq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr),
    .wr_job (q_in),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_job (q_out),
    .empty  (q_empty)
  );

  // back: unit conversion and result queue
  ttd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (!q_empty),
    .job       (q_out),
    .job_take  (q_rd),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign valid_res   = res.valid_res;
  assign infinite    = res.infinite;
  assign seconds     = res.seconds;
  assign nanoseconds = res.nanoseconds;

  // head result carries no duration at all
  assign dur_zero = (seconds == '0) && (nanoseconds == '0);

  // a malformed result carries no duration
  `TTD_CHECK_NOW(a_bad_is_zero, !empty && !valid_res, !infinite && dur_zero, "bad result nonzero")
  // an infinite result is valid and has zero duration
  `TTD_CHECK_NOW(a_inf_shape, !empty && infinite, valid_res && dur_zero, "infinite with duration")
  // nanosecond remainder stays below one second
  `TTD_CHECK_NOW(a_ns_range, !empty, nanoseconds < NS_PER_S, "nanosecond remainder out of range")
  // a job transfer never lands in a full queue
  `TTD_CHECK_NOW(a_jobq_room, q_wr, !q_full, "job written into full queue")
  // a job taken from the queue was present
  `TTD_CHECK_NEXT(a_take_valid, q_rd, !$past(q_empty), "job taken from empty queue")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the duration text decoder: streams characters in,
// predicts each parsed result in the bench and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import ttd_pkg::*;

  // Parse phases of the bench's own copy of the decoder.
  typedef enum logic [2:0] {
    P_LEAD, P_DIGITS, P_GAP, P_TRAIL, P_ENDED, P_INF, P_BAD
  } parse_phase_e;

  // One character transfer as queued for the driver.
  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       lst;
  } char_item_t;

  localparam int RandomItems = 1550;
  localparam int StallLimit  = 2000;  // cycles with no transfer on either side
  localparam int DrainCycles = 24;    // wait after both queues empty, before the final check

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_code = 8'h00;
  logic        has_char = 1'b0;
  logic        last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        valid_res;
  logic        infinite;
  logic [41:0] seconds;
  logic [29:0] nanoseconds;

  char_item_t pending_chars[$];
  result_t    expected_results[$];
  result_t    want;

  // Predictor state.
  parse_phase_e      text_phase = P_LEAD;
  logic [CountW-1:0] text_count = '0;
  logic [2:0]        text_unit  = UNIT_NS;

  int items_total = 0;
  int items_sent  = 0;
  int n_texts     = 0;
  int n_infinite  = 0;
  int n_malformed = 0;
  int n_checked   = 0;
  int fail_count  = 0;
  int stall_count = 0;
  int stage       = 0;  // 0: both idle, sender less; 1: swapped; 2: no idling

  timeout_text_decoder u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .char_code   (char_code),
    .has_char    (has_char),
    .last        (last),
    .empty       (empty),
    .pop         (pop),
    .valid_res   (valid_res),
    .infinite    (infinite),
    .seconds     (seconds),
    .nanoseconds (nanoseconds)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor: advances the parse on one accepted character transfer and,
  // on the item marked last, queues the expected result and starts afresh.
  // --------------------------------------------------------------------------
  task automatic decode_item(input logic [7:0] c, input logic has, input logic lst);
    logic              is_digit;
    logic [CountW-1:0] dval;
    logic              unit_ok;
    logic [2:0]        ucode;
    logic [63:0]       x;
    logic [63:0]       sec;
    logic [63:0]       ns;
    result_t           r;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    dval     = CountW'(c - CH_ZERO);
    unit_ok  = 1'b1;
    ucode    = UNIT_NS;
    case (c)
      CH_N:    ucode = UNIT_NS;
      CH_U:    ucode = UNIT_US;
      CH_LM:   ucode = UNIT_MS;
      CH_US:   ucode = UNIT_S;
      CH_UM:   ucode = UNIT_M;
      CH_UH:   ucode = UNIT_H;
      default: unit_ok = 1'b0;
    endcase
    if (has) begin
      case (text_phase)
        P_LEAD: begin
          if (c == CH_SPACE) begin
          end else if (is_digit) begin
            text_count = dval;
            text_phase = P_DIGITS;
          end else begin
            text_phase = P_BAD;
          end
        end
        P_DIGITS: begin
          if (is_digit) begin
            // one more digit may push the count past one billion
            if (text_count >= COUNT_LIMIT && (text_count != COUNT_LIMIT || dval != 0))
              text_phase = P_INF;
            else
              text_count = text_count * CountW'(10) + dval;
          end else if (c == CH_SPACE) begin
            text_phase = P_GAP;
          end else if (unit_ok) begin
            text_unit  = ucode;
            text_phase = P_TRAIL;
          end else begin
            text_phase = P_BAD;
          end
        end
        P_GAP: begin
          if (c == CH_SPACE) begin
          end else if (unit_ok) begin
            text_unit  = ucode;
            text_phase = P_TRAIL;
          end else begin
            text_phase = P_BAD;
          end
        end
        P_TRAIL: begin
          if (c == CH_NUL) text_phase = P_ENDED;
          else if (c != CH_SPACE) text_phase = P_BAD;
        end
        P_ENDED, P_INF, P_BAD: begin
        end
        default: text_phase = P_BAD;
      endcase
    end
    if (lst) begin
      r   = '0;
      x   = 64'(text_count);
      sec = '0;
      ns  = '0;
      if (text_phase == P_INF) begin
        r.valid_res = 1'b1;
        r.infinite  = 1'b1;
        n_infinite++;
      end else if (text_phase == P_TRAIL || text_phase == P_ENDED) begin
        r.valid_res = 1'b1;
        case (text_unit)
          UNIT_NS: begin
            sec = x / NS_PER_S;
            ns  = x % NS_PER_S;
          end
          UNIT_US: begin
            sec = x / NS_PER_MS;
            ns  = (x % NS_PER_MS) * NS_PER_US;
          end
          UNIT_MS: begin
            sec = x / NS_PER_US;
            ns  = (x % NS_PER_US) * NS_PER_MS;
          end
          UNIT_S:  sec = x;
          UNIT_M:  sec = x * 64'd60;
          UNIT_H:  sec = x * 64'd3600;
          default: r.valid_res = 1'b0;
        endcase
        r.seconds     = sec[SecW-1:0];
        r.nanoseconds = ns[NsW-1:0];
      end
      if (!r.valid_res) n_malformed++;
      expected_results.push_back(r);
      text_phase = P_LEAD;
      text_count = '0;
      text_unit  = UNIT_NS;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers: append character transfers to the driver's queue.
  // --------------------------------------------------------------------------
  task automatic put(input logic [7:0] c, input logic has, input logic lst);
    char_item_t it;
    it.ch  = c;
    it.has = has;
    it.lst = lst;
    pending_chars.push_back(it);
    items_total++;
    if (lst) n_texts++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i], 1'b1, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Driver: one character transfer per accepted push. A held push stays up
  // while full is high; otherwise the sender idles at the current stage rate.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      push       <= 1'b0;
      text_phase = P_LEAD;
      text_count = '0;
      text_unit  = UNIT_NS;
    end else begin
      if (push && !full) begin
        decode_item(char_code, has_char, last);
        void'(pending_chars.pop_front());
        items_sent++;
        stage <= (items_sent * 3) / items_total;
      end
      if (push && full) begin
        // keep the current transfer on the ports until it is taken
      end else if (pending_chars.size() != 0 &&
                   $urandom_range(99) >= (stage == 0 ? 35 : stage == 1 ? 58 : 0)) begin
        push      <= 1'b1;
        char_code <= pending_chars[0].ch;
        has_char  <= pending_chars[0].has;
        last      <= pending_chars[0].lst;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every result transfer is checked against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_checked++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected result: valid=%0d inf=%0d s=%0d ns=%0d",
                     valid_res, infinite, seconds, nanoseconds);
        end else begin
          want = expected_results.pop_front();
          if (valid_res !== want.valid_res || infinite !== want.infinite ||
              seconds !== want.seconds || nanoseconds !== want.nanoseconds) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: #%0d exp v=%0d i=%0d s=%0d ns=%0d got v=%0d i=%0d s=%0d ns=%0d",
                       n_checked, want.valid_res, want.infinite, want.seconds,
                       want.nanoseconds, valid_res, infinite, seconds, nanoseconds);
          end
        end
      end
      pop <= ($urandom_range(99) >= (stage == 0 ? 58 : stage == 1 ? 35 : 0));
    end
  end

  // Watchdog: ends the run when neither side has moved for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_count <= 0;
    end else if (stall_count >= StallLimit) begin
      $display("ERROR: no transfer for %0d cycles", StallLimit);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] txt[$];
    logic [7:0] units[6];
    int         directed_items;
    int         pos;
    logic       end_empty;
    units = '{CH_N, CH_U, CH_LM, CH_US, CH_UM, CH_UH};

    // Directed texts: extremes, every unit, each malformed form.
    put_text("1000000000"); put(CH_N, 1'b1, 1'b1);       // largest finite count, ns
    put_text("999999999");  put(CH_U, 1'b1, 1'b1);       // us with full remainder
    put_text("1000000000"); put(CH_UH, 1'b1, 1'b1);      // largest seconds value
    put_text("1000000001"); put(CH_NUL, 1'b1, 1'b0);     // infinite, rest ignored
    put(8'hFF, 1'b1, 1'b1);
    put_text(" 0 m ");      put(8'h00, 1'b0, 1'b1);      // ends on an empty item
    put_text("7M");         put(CH_NUL, 1'b1, 1'b1);     // zero byte ends the text
    put_text("4");          put(8'hA5, 1'b0, 1'b0);      // byte-less item mid count
    put_text("2S 0");       put(CH_NUL, 1'b1, 1'b1);     // digit after the unit
    put_text("12 3");       put(CH_US, 1'b1, 1'b1);      // digit after spaces
    put(CH_UH, 1'b1, 1'b1);                              // unit with no digit
    put_text("12");         put(8'h00, 1'b0, 1'b1);      // no unit
    put(8'h00, 1'b0, 1'b1);                              // empty text
    put_text("5S");         put(CH_NUL, 1'b1, 1'b0);     // junk after zero byte
    put(8'h7A, 1'b1, 1'b1);
    directed_items = items_total;

    // Random texts: mostly well formed with random content, the rest broken.
    while (items_total - directed_items < RandomItems) begin
      txt.delete();
      if ($urandom_range(19) == 0) begin
        repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(2)) txt.push_back(CH_SPACE);
        if ($urandom_range(7) == 0) begin
          // around the one-billion limit
          txt.push_back(CH_ZERO + 8'd1);
          repeat (8) txt.push_back(CH_ZERO);
          repeat ($urandom_range(1, 2)) txt.push_back(CH_ZERO + 8'($urandom_range(1)));
        end else begin
          repeat ($urandom_range(3) == 0 ? $urandom_range(10, 11) : $urandom_range(1, 9))
            txt.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
        repeat ($urandom_range(2)) txt.push_back(CH_SPACE);
        txt.push_back(units[$urandom_range(5)]);
        repeat ($urandom_range(2)) txt.push_back(CH_SPACE);
        if ($urandom_range(3) == 0) begin
          txt.push_back(CH_NUL);
          repeat ($urandom_range(2)) txt.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(4) == 0) begin
          pos = $urandom_range(txt.size() - 1);
          case ($urandom_range(3))
            0: txt[pos] = 8'($urandom_range(255));
            1: txt[pos] = CH_SPACE;
            2: txt[pos] = CH_ZERO + 8'($urandom_range(9));
            default: txt[pos] = units[$urandom_range(5)];
          endcase
        end
      end
      end_empty = ($urandom_range(5) == 0);
      foreach (txt[i]) begin
        if ($urandom_range(19) == 0) put(8'($urandom_range(255)), 1'b0, 1'b0);
        put(txt[i], 1'b1, (i == txt.size() - 1) && !end_empty);
      end
      if (end_empty) put(8'($urandom_range(255)), 1'b0, 1'b1);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (expected_results.size() != 0) begin
      fail_count++;
      $display("ERROR: %0d expected results never arrived", expected_results.size());
    end
    $display("Streamed %0d texts in %0d character transfers across three idling stages.",
             n_texts, items_total);
    $display("Checked %0d results: %0d infinite, %0d malformed; %0d failures.",
             n_checked, n_infinite, n_malformed, fail_count);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
